// ===== design/afrg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afrg_pkg
// Shared types and constants of the AV1 OBU to RTP payload fragmenter.
// ----------------------------------------------------------------------------
package afrg_pkg;

	// Largest OBU length honored; longer lengths are clamped to this.
	localparam int unsigned MAX_OBU_BYTES = 1048575;

	// Configuration register reset value, and the smallest payload size honored
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1420;
	localparam logic [15:0] MIN_PAYLOAD     = 16'd2;

	// Aggregation header bits
	localparam logic [7:0] HDR_W1 = 8'h10;
	localparam logic [7:0] HDR_N  = 8'h08;
	localparam logic [7:0] HDR_Y  = 8'h40;
	localparam logic [7:0] HDR_Z  = 8'h80;

	// OBU type of a sequence header (sets N on the first chunk)
	localparam logic [3:0] OBU_TYPE_SEQ_HDR = 4'h1;

	// Configuration register indexes
	localparam logic REG_MAX_PAYLOAD = 1'b0;
	localparam logic REG_PASSTHROUGH = 1'b1;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [19:0] obu_length;
		logic        frame_marker;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_start;
		logic       packet_end;
		logic       marker;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic [15:0] max_payload;
		logic        passthrough_mode;
	} cfg_t;

endpackage
`default_nettype wire

// ===== design/av1_obu_rtp_fragmenter.sv =====
`default_nettype none
// An accepted byte passes the input register and then the output register.
// Throughput: one byte per cycle while the output is not stalled; a byte that opens
//   a chunk also needs a header beat ahead of its data beat, both sharing the output register.
// Reset (arst_n low): pipeline emptied, OBU offset and chunk fill cleared,
//   max_payload = 1420, passthrough_mode = 0.
// ----------------------------------------------------------------------------
// av1_obu_rtp_fragmenter
// Cuts an AV1 OBU byte stream into RTP payloads with aggregation headers.
// ----------------------------------------------------------------------------
module av1_obu_rtp_fragmenter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input byte stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [7:0] data_byte, [27:8] obu_length, [31:28] zero
	input  wire logic        s_tlast,  // frame_marker
	// Payload byte stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [7:0] out_byte
	output logic             m_tlast,  // packet_end
	output logic [2:0]       m_tuser,  // [0] packet_start, [1] marker, [2] run_last
	// Configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	afrg_pkg::cfg_t    cfg_q;
	afrg_pkg::item_t   in_item;
	afrg_pkg::item_t   item;
	afrg_pkg::result_t res;
	afrg_pkg::result_t out_res_q;
	logic              item_valid;
	logic              take;
	logic              res_valid;
	logic              adv;
	logic              out_valid_q;

	// Configuration registers: word index in paddr[2]
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload      <= afrg_pkg::MAX_PAYLOAD_RST;
			cfg_q.passthrough_mode <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				afrg_pkg::REG_MAX_PAYLOAD: cfg_q.max_payload      <= pwdata[15:0];
				afrg_pkg::REG_PASSTHROUGH: cfg_q.passthrough_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			afrg_pkg::REG_MAX_PAYLOAD: prdata = {16'd0, cfg_q.max_payload};
			afrg_pkg::REG_PASSTHROUGH: prdata = {31'd0, cfg_q.passthrough_mode};
			default:                   prdata = 32'd0;
		endcase
	end

	// Unpack the input beat
	assign in_item.data_byte    = s_tdata[7:0];
	assign in_item.obu_length   = s_tdata[27:8];
	assign in_item.frame_marker = s_tlast;

	// Hold the accepted byte until its data beat leaves
	afrg_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	// Form the header or data beat and advance the chunk state
	afrg_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.adv        (adv),
		.res_valid  (res_valid),
		.res        (res),
		.take       (take)
	);

	// Output register: load whenever empty or being drained
	assign adv = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_res_q.out_byte;
	assign m_tlast  = out_res_q.packet_end;
	assign m_tuser  = {out_res_q.run_last, out_res_q.marker, out_res_q.packet_start};

endmodule
`default_nettype wire

// ===== design/afrg_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afrg_in_reg
// Input register: holds one accepted byte until its data beat is emitted.
// ----------------------------------------------------------------------------
module afrg_in_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire afrg_pkg::item_t in_item,
	input  wire logic            take,
	output logic                 item_valid,
	output afrg_pkg::item_t      item
);

	logic            valid_s1;
	afrg_pkg::item_t item_s1;

	// Refill in the same cycle the held byte leaves
	assign in_ready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// ===== design/afrg_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afrg_emit
// Chunk state and results: header then data beat, data only in passthrough.
// ----------------------------------------------------------------------------
module afrg_emit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire afrg_pkg::cfg_t    cfg,
	input  wire logic              item_valid,
	input  wire afrg_pkg::item_t   item,
	input  wire logic              adv,
	output logic                   res_valid,
	output afrg_pkg::result_t      res,
	output logic                   take
);

	logic [19:0] obu_offset_q;
	logic [15:0] chunk_fill_q;
	logic        hdr_sent_q;

	logic [19:0] len;
	logic        obu_end;
	logic [15:0] cap;
	logic [19:0] remaining;
	logic        tail_chunk;
	logic        pkt_end;
	logic        need_hdr;
	logic [7:0]  hdr;

	always_comb begin
		if (item.obu_length == 20'd0) begin
			len = 20'd1;
		end else if (32'(item.obu_length) > afrg_pkg::MAX_OBU_BYTES) begin
			len = 20'(afrg_pkg::MAX_OBU_BYTES);
		end else begin
			len = item.obu_length;
		end
	end

	assign obu_end = ({1'b0, obu_offset_q} + 21'd1) >= {1'b0, len};

	assign cap = ((cfg.max_payload < afrg_pkg::MIN_PAYLOAD) ?
		afrg_pkg::MIN_PAYLOAD : cfg.max_payload) - 16'd1;

	assign remaining  = (len > obu_offset_q) ? (len - obu_offset_q) : 20'd1;
	assign tail_chunk = remaining <= {4'd0, cap};
	assign pkt_end    = obu_end || (({1'b0, chunk_fill_q} + 17'd1) >= {1'b0, cap});
	assign need_hdr   = !cfg.passthrough_mode && (chunk_fill_q == 16'd0) && !hdr_sent_q;

	always_comb begin
		hdr = afrg_pkg::HDR_W1;
		if (obu_offset_q != 20'd0) begin
			hdr = hdr | afrg_pkg::HDR_Z;
		end
		if (!tail_chunk) begin
			hdr = hdr | afrg_pkg::HDR_Y;
		end
		if (obu_offset_q == 20'd0 && item.data_byte[6:3] == afrg_pkg::OBU_TYPE_SEQ_HDR) begin
			hdr = hdr | afrg_pkg::HDR_N;
		end
	end

	always_comb begin
		res = '0;
		if (cfg.passthrough_mode) begin
			res.out_byte     = item.data_byte;
			res.packet_start = obu_offset_q == 20'd0;
			res.packet_end   = obu_end;
			res.marker       = obu_end && item.frame_marker;
			res.run_last     = 1'b1;
		end else if (need_hdr) begin
			res.out_byte     = hdr;
			res.packet_start = 1'b1;
		end else begin
			res.out_byte   = item.data_byte;
			res.packet_end = pkt_end;
			res.marker     = pkt_end && obu_end;
			res.run_last   = 1'b1;
		end
	end

	assign res_valid = item_valid;
	assign take      = item_valid && adv && !need_hdr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obu_offset_q <= '0;
			chunk_fill_q <= '0;
			hdr_sent_q   <= 1'b0;
		end else if (item_valid && adv) begin
			if (need_hdr) begin
				hdr_sent_q <= 1'b1;
			end else begin
				hdr_sent_q   <= 1'b0;
				obu_offset_q <= obu_end ? 20'd0 : obu_offset_q + 20'd1;
				if (cfg.passthrough_mode || pkt_end) begin
					chunk_fill_q <= 16'd0;
				end else begin
					chunk_fill_q <= chunk_fill_q + 16'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_av1_obu_rtp_fragmenter.sv =====
// ----------------------------------------------------------------------------
// tb_av1_obu_rtp_fragmenter
// Self-checking bench for the AV1 OBU to RTP payload fragmenter. A clocked
// driver feeds OBU bytes from a queue, a behavioral fragmenter predicts the
// payload beats of every accepted byte, and a clocked monitor compares each
// payload beat with the oldest prediction. Payload size and passthrough are
// reprogrammed over APB between phases, and both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_av1_obu_rtp_fragmenter;
	timeunit 1ns;
	timeprecision 1ps;

	// Register byte addresses: register i sits at 4*i
	localparam logic [2:0] ADDR_MAX_PAYLOAD = {afrg_pkg::REG_MAX_PAYLOAD, 2'b00};
	localparam logic [2:0] ADDR_PASSTHROUGH = {afrg_pkg::REG_PASSTHROUGH, 2'b00};

	localparam int RANDOM_BYTES  = 1900;
	localparam int STALL_LIMIT   = 2000; // cycles with no beat and no APB access
	localparam int SETTLE_CYCLES = 6;    // slack after the last predicted beat
	localparam int MAX_REPORTS   = 10;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;     // [7:0] data_byte, [27:8] obu_length, [31:28] zero
	logic        s_tlast  = 1'b0;   // frame_marker
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [7:0]  m_tdata;           // [7:0] out_byte
	logic        m_tlast;           // packet_end
	logic [2:0]  m_tuser;           // [0] packet_start, [1] marker, [2] run_last
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	av1_obu_rtp_fragmenter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes waiting to be offered, and payload beats the fragmenter must produce
	afrg_pkg::item_t   obu_q[$];
	afrg_pkg::result_t payload_q[$];

	// Shadow of the fragmenter: registers and OBU / chunk position
	logic [15:0] cfg_max_payload = afrg_pkg::MAX_PAYLOAD_RST;
	logic        cfg_passthrough = 1'b0;
	logic [19:0] frag_offset     = '0;
	logic [15:0] frag_fill       = '0;

	// Idling control; percentages are per decision
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned src_gap      = 0;
	int unsigned snk_gap      = 0;

	int unsigned errors      = 0;
	int unsigned stall_count = 0;
	int unsigned queued      = 0;

	// Predict the payload beats caused by one accepted OBU byte.
	task automatic fragment_byte(input afrg_pkg::item_t it);
		logic [19:0]       len;
		logic              obu_end;
		logic              tail_chunk;
		logic              pkt_end;
		int unsigned       mp;
		int unsigned       cap;
		int unsigned       remaining;
		logic [7:0]        hdr;
		afrg_pkg::result_t r;

		len = it.obu_length;
		if (len == 0)
			len = 20'd1;           // zero length counts as a one-byte OBU
		if (len > afrg_pkg::MAX_OBU_BYTES)
			len = 20'(afrg_pkg::MAX_OBU_BYTES);
		obu_end = ({12'd0, frag_offset} + 32'd1 >= {12'd0, len});

		if (cfg_passthrough) begin
			// Forward as is: one packet per OBU, marker from the input
			r.out_byte     = it.data_byte;
			r.packet_start = (frag_offset == 0);
			r.packet_end   = obu_end;
			r.marker       = obu_end & it.frame_marker;
			r.run_last     = 1'b1;
			payload_q.push_back(r);
			frag_fill   = '0;
			frag_offset = obu_end ? 20'd0 : frag_offset + 20'd1;
			return;
		end

		mp  = 32'((cfg_max_payload < afrg_pkg::MIN_PAYLOAD) ?
			afrg_pkg::MIN_PAYLOAD : cfg_max_payload);
		cap = mp - 1;                  // data bytes per chunk after the header

		if (frag_fill == 0) begin
			// Open a chunk: aggregation header beat ahead of the data
			remaining  = (len > frag_offset) ? len - frag_offset : 1;
			tail_chunk = (remaining <= cap);
			hdr = afrg_pkg::HDR_W1;
			if (frag_offset != 0)
				hdr = hdr | afrg_pkg::HDR_Z;
			if (!tail_chunk)
				hdr = hdr | afrg_pkg::HDR_Y;
			if (frag_offset == 0 && it.data_byte[6:3] == afrg_pkg::OBU_TYPE_SEQ_HDR)
				hdr = hdr | afrg_pkg::HDR_N;
			r.out_byte     = hdr;
			r.packet_start = 1'b1;
			r.packet_end   = 1'b0;
			r.marker       = 1'b0;
			r.run_last     = 1'b0;
			payload_q.push_back(r);
		end

		pkt_end = obu_end || ({16'd0, frag_fill} + 32'd1 >= cap);
		r.out_byte     = it.data_byte;
		r.packet_start = 1'b0;
		r.packet_end   = pkt_end;
		r.marker       = pkt_end & obu_end;
		r.run_last     = 1'b1;
		payload_q.push_back(r);

		frag_fill   = pkt_end ? 16'd0 : frag_fill + 16'd1;
		frag_offset = obu_end ? 20'd0 : frag_offset + 20'd1;
	endtask

	// Input side: present queued bytes, predict on every accepted beat.
	always @(posedge clk or negedge arst_n) begin : drive
		afrg_pkg::item_t acc;
		afrg_pkg::item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			src_gap  <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				acc.data_byte    = s_tdata[7:0];
				acc.obu_length   = s_tdata[27:8];
				acc.frame_marker = s_tlast;
				fragment_byte(acc);
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					src_gap  <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (obu_q.size() != 0 && $urandom_range(0, 99) < src_idle_pct) begin
					src_gap  <= $urandom_range(0, 6);
					s_tvalid <= 1'b0;
				end else if (obu_q.size() != 0) begin
					nxt = obu_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'd0, nxt.obu_length, nxt.data_byte};
					s_tlast  <= nxt.frame_marker;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: check every payload beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : watch
		afrg_pkg::result_t got;
		afrg_pkg::result_t want;
		if (!arst_n) begin
			m_tready <= 1'b1;
			snk_gap  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.out_byte     = m_tdata;
				got.packet_start = m_tuser[0];
				got.packet_end   = m_tlast;
				got.marker       = m_tuser[1];
				got.run_last     = m_tuser[2];
				if (payload_q.size() == 0) begin
					errors = errors + 1;
					if (errors <= MAX_REPORTS)
						$display("unexpected beat at %0t: byte %02h start %b end %b marker %b last %b",
							$realtime, got.out_byte, got.packet_start, got.packet_end,
							got.marker, got.run_last);
				end else begin
					want = payload_q.pop_front();
					if (got !== want) begin
						errors = errors + 1;
						if (errors <= MAX_REPORTS)
							$display("mismatch at %0t: expected %02h s/e/m/l %b%b%b%b, got %02h s/e/m/l %b%b%b%b",
								$realtime, want.out_byte, want.packet_start, want.packet_end,
								want.marker, want.run_last, got.out_byte, got.packet_start,
								got.packet_end, got.marker, got.run_last);
					end
				end
			end
			if (snk_gap != 0) begin
				snk_gap  <= snk_gap - 1;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < snk_idle_pct) begin
				snk_gap  <= $urandom_range(0, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when nothing has moved for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// APB write: setup cycle, access cycle; the register takes it at the access edge.
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_MAX_PAYLOAD)
			cfg_max_payload = value[15:0];
		else
			cfg_passthrough = value[0];
	endtask

	task automatic push_byte(input logic [7:0] b, input logic [19:0] len, input logic mark);
		afrg_pkg::item_t it;
		it.data_byte    = b;
		it.obu_length   = len;
		it.frame_marker = mark;
		obu_q.push_back(it);
		queued = queued + 1;
	endtask

	// Queue count bytes of an OBU of length len; the first byte is given.
	task automatic push_obu(input logic [19:0] len, input logic [7:0] first, input logic mark,
			input int unsigned count);
		push_byte(first, len, mark);
		for (int unsigned k = 1; k < count; k++)
			push_byte(8'($urandom), len, mark);
	endtask

	// Hold until every byte is taken and every predicted beat has come out.
	task automatic drain();
		@(negedge clk);
		while (obu_q.size() != 0 || s_tvalid || payload_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned target;
		int unsigned n;
		int unsigned pick;
		logic [15:0] mp;
		logic        pt;
		logic [19:0] len;
		logic [7:0]  first;
		logic        quiet;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: single-byte sequence header (N), two-byte OBU, zero length
		push_byte(8'h08, 20'd1, 1'b1);
		push_byte(8'hFF, 20'd2, 1'b0);
		push_byte(8'h00, 20'd2, 1'b1);
		push_byte(8'h0F, 20'd0, 1'b1);
		drain();

		// Smallest payload: one data byte per chunk
		write_reg(ADDR_MAX_PAYLOAD, 32'd2);
		push_obu(20'd3, 8'h0B, 1'b0, 3);
		drain();
		write_reg(ADDR_MAX_PAYLOAD, 32'd3);
		push_obu(20'd5, 8'h80, 1'b1, 5);
		drain();

		// Shrink the payload while a chunk is open
		write_reg(ADDR_MAX_PAYLOAD, 32'd65535);
		push_obu(20'd6, 8'h7F, 1'b0, 3);
		drain();
		write_reg(ADDR_MAX_PAYLOAD, 32'd3);
		push_obu(20'd6, 8'h55, 1'b1, 3);
		drain();

		// Passthrough, then leave it in the middle of an OBU
		write_reg(ADDR_PASSTHROUGH, 32'd1);
		push_obu(20'd3, 8'h08, 1'b1, 3);
		push_obu(20'd4, 8'h08, 1'b0, 2);
		drain();
		write_reg(ADDR_PASSTHROUGH, 32'd0);
		push_obu(20'd4, 8'hAA, 1'b1, 2);
		drain();

		// Longest length, cut short by a byte whose length it already reached
		push_byte(8'h08, 20'hFFFFF, 1'b0);
		push_byte(8'hC3, 20'hFFFFF, 1'b1);
		push_byte(8'h3C, 20'd1, 1'b1);
		drain();

		// Random phases; the open OBU and chunk carry across register writes
		queued = 0;
		quiet  = 1'b0;
		while (queued < RANDOM_BYTES) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0:       mp = 16'd0;
				1:       mp = 16'd1;
				2:       mp = 16'd2;
				3:       mp = 16'd3;
				4:       mp = 16'd65535;
				5:       mp = afrg_pkg::MAX_PAYLOAD_RST;
				6:       mp = 16'($urandom_range(4, 64));
				7:       mp = 16'($urandom);
				default: mp = 16'($urandom_range(2, 12));
			endcase
			pt = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 1)) begin
				write_reg(ADDR_MAX_PAYLOAD, {16'd0, mp});
				write_reg(ADDR_PASSTHROUGH, {31'd0, pt});
			end else begin
				write_reg(ADDR_PASSTHROUGH, {31'd0, pt});
				write_reg(ADDR_MAX_PAYLOAD, {16'd0, mp});
			end

			// The tail of the run goes without any idling
			quiet = (RANDOM_BYTES - queued <= 250);
			if (quiet) begin
				target = RANDOM_BYTES - queued;
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else begin
				target = $urandom_range(100, 220);
				case ($urandom_range(0, 3))
					0: src_idle_pct = 0;
					1: src_idle_pct = 10;
					2: src_idle_pct = 25;
					default: src_idle_pct = 40;
				endcase
				case ($urandom_range(0, 3))
					0: snk_idle_pct = 0;
					1: snk_idle_pct = 10;
					2: snk_idle_pct = 25;
					default: snk_idle_pct = 40;
				endcase
			end
			target = queued + target;

			while (queued < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					// Well-formed OBU, sometimes a sequence header, mostly short
					len = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(31, 400))
						: 20'($urandom_range(1, 30));
					if ($urandom_range(0, 3) == 0)
						first = {1'($urandom), afrg_pkg::OBU_TYPE_SEQ_HDR, 3'($urandom)};
					else
						first = 8'($urandom);
					push_obu(len, first, 1'($urandom), 32'(len));
				end else if (pick < 88) begin
					// Length changes under way: any 20-bit length, ended by a short one
					len = 20'($urandom);
					push_obu(len, 8'($urandom), 1'($urandom), $urandom_range(1, 5));
					push_byte(8'($urandom), 20'($urandom_range(0, 1)), 1'($urandom));
				end else if (pick < 94) begin
					n = $urandom_range(1, 3);
					for (int unsigned k = 0; k < n; k++)
						push_byte(8'($urandom), 20'd0, 1'($urandom));
				end else begin
					// Noise: every byte with its own small length and marker
					n = $urandom_range(1, 6);
					for (int unsigned k = 0; k < n; k++)
						push_byte(8'($urandom), 20'($urandom_range(1, 8)), 1'($urandom));
				end
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (payload_q.size() != 0)
			errors = errors + 1;
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/afrg_pkg.sv
design/afrg_in_reg.sv
design/afrg_emit.sv
design/av1_obu_rtp_fragmenter.sv
tb/tb_av1_obu_rtp_fragmenter.sv
